@@ rtl/dls_pkg.sv @@
// dls_pkg: shared types, widths and codes for the display link supervisor.
// No dependencies; every other file imports it.
package dls_pkg;

  localparam int CMD_W     = 3;
  localparam int VER_W     = 16;
  localparam int PAGE_W    = 8;
  localparam int COMP_W    = 8;
  localparam int HB_W      = 6;
  localparam int RELOAD_W  = 5;
  localparam int SPAN_W    = 5;
  localparam int DECAY_W   = 8;
  localparam int LS_W      = 2;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // page history
  localparam int HISTORY_DEPTH = 5;
  localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HIST_CNT_W    = $clog2(HISTORY_DEPTH + 1);

  localparam logic [PAGE_W-1:0] REFUSED_PAGE = 8'hff;

  // event codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_VERSION = 3'd1,
    CMD_ECHO    = 3'd2,
    CMD_SWITCH  = 3'd3,
    CMD_BACK    = 3'd4,
    CMD_SELECT  = 3'd5,
    CMD_CLEAR   = 3'd6
  } cmd_t;

  // reported link state codes
  localparam logic [LS_W-1:0] LS_DISC  = 2'd0;
  localparam logic [LS_W-1:0] LS_CONN  = 2'd1;
  localparam logic [LS_W-1:0] LS_OPER  = 2'd2;
  localparam logic [LS_W-1:0] LS_WRONG = 2'd3;

  // link state machine
  typedef enum logic [3:0] {
    MODE_DISC  = 4'b0001,
    MODE_CONN  = 4'b0010,
    MODE_OPER  = 4'b0100,
    MODE_WRONG = 4'b1000
  } link_mode_t;

  // register map indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MIN_VER   = 3'd0;
  localparam logic [2:0] REG_MAX_VER   = 3'd1;
  localparam logic [2:0] REG_INIT_PAGE = 3'd2;
  localparam logic [2:0] REG_FALLBACK  = 3'd3;
  localparam logic [2:0] REG_WD_RELOAD = 3'd4;
  localparam logic [2:0] REG_RETRY     = 3'd5;
  localparam logic [2:0] REG_DECAY     = 3'd6;

  typedef struct packed {
    logic [VER_W-1:0]    min_version;
    logic [VER_W-1:0]    max_version;
    logic [PAGE_W-1:0]   init_page;
    logic [PAGE_W-1:0]   fallback_page;
    logic [RELOAD_W-1:0] watchdog_reload;
    logic [SPAN_W-1:0]   retry_span;
    logic [DECAY_W-1:0]  select_decay;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [VER_W-1:0]  version;
    logic [PAGE_W-1:0] page_id;
    logic              push_history;
    logic [COMP_W-1:0] component_id;
  } item_t;

  typedef struct packed {
    logic [LS_W-1:0]   link_state;
    logic              ping_sent;
    logic              reset_sent;
    logic              timeout_alert;
    logic              version_alert;
    logic              init_entered;
    logic              page_sent;
    logic [PAGE_W-1:0] active_page;
    logic              deselect_sent;
    logic [COMP_W-1:0] deselect_id;
    logic              select_sent;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } hist_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } hist_stat_t;

  function automatic logic [LS_W-1:0] encode_mode(input link_mode_t m);
    logic [LS_W-1:0] code;
    case (m)
      MODE_DISC:  code = LS_DISC;
      MODE_CONN:  code = LS_CONN;
      MODE_OPER:  code = LS_OPER;
      MODE_WRONG: code = LS_WRONG;
      default:    code = LS_DISC;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/dls_if.sv @@
// dls_if: valid/ready channel interfaces for event beats and result beats.
// Depends on dls_pkg for field widths.
interface dls_in_if
  import dls_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [VER_W-1:0]  version;
  logic [PAGE_W-1:0] page_id;
  logic              push_history;
  logic [COMP_W-1:0] component_id;

  modport source (output valid, command, version, page_id, push_history, component_id,
                  input ready);
  modport sink   (input valid, command, version, page_id, push_history, component_id,
                  output ready);
endinterface

interface dls_out_if
  import dls_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [LS_W-1:0]   link_state;
  logic              ping_sent;
  logic              reset_sent;
  logic              timeout_alert;
  logic              version_alert;
  logic              init_entered;
  logic              page_sent;
  logic [PAGE_W-1:0] active_page;
  logic              deselect_sent;
  logic [COMP_W-1:0] deselect_id;
  logic              select_sent;

  modport source (output valid, link_state, ping_sent, reset_sent, timeout_alert,
                  version_alert, init_entered, page_sent, active_page, deselect_sent,
                  deselect_id, select_sent, input ready);
  modport sink   (input valid, link_state, ping_sent, reset_sent, timeout_alert,
                  version_alert, init_entered, page_sent, active_page, deselect_sent,
                  deselect_id, select_sent, output ready);
endinterface

@@ rtl/dls_cfg.sv @@
// dls_cfg: APB-style register file holding the supervisor configuration.
// Depends on dls_pkg.
module dls_cfg
  import dls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_version     <= VER_W'(1);
      cfg_r.max_version     <= VER_W'(1);
      cfg_r.init_page       <= PAGE_W'(0);
      cfg_r.fallback_page   <= PAGE_W'(1);
      cfg_r.watchdog_reload <= RELOAD_W'(8);
      cfg_r.retry_span      <= SPAN_W'(16);
      cfg_r.select_decay    <= DECAY_W'(20);
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_VER:   cfg_r.min_version     <= pwdata[VER_W-1:0];
        REG_MAX_VER:   cfg_r.max_version     <= pwdata[VER_W-1:0];
        REG_INIT_PAGE: cfg_r.init_page       <= pwdata[PAGE_W-1:0];
        REG_FALLBACK:  cfg_r.fallback_page   <= pwdata[PAGE_W-1:0];
        REG_WD_RELOAD: cfg_r.watchdog_reload <= pwdata[RELOAD_W-1:0];
        REG_RETRY:     cfg_r.retry_span      <= pwdata[SPAN_W-1:0];
        REG_DECAY:     cfg_r.select_decay    <= pwdata[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_VER:   prdata = DATA_W'(cfg_r.min_version);
      REG_MAX_VER:   prdata = DATA_W'(cfg_r.max_version);
      REG_INIT_PAGE: prdata = DATA_W'(cfg_r.init_page);
      REG_FALLBACK:  prdata = DATA_W'(cfg_r.fallback_page);
      REG_WD_RELOAD: prdata = DATA_W'(cfg_r.watchdog_reload);
      REG_RETRY:     prdata = DATA_W'(cfg_r.retry_span);
      REG_DECAY:     prdata = DATA_W'(cfg_r.select_decay);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ rtl/dls_history.sv @@
// dls_history: page history stack, register-based, with a fill count.
// Depends on dls_pkg.
module dls_history
  import dls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  hist_ctl_t         ctl,
  input  logic [PAGE_W-1:0] push_data,
  output logic [PAGE_W-1:0] top_data,
  output hist_stat_t        stat
);

  logic [PAGE_W-1:0]     stack_r [HISTORY_DEPTH];
  logic [HIST_CNT_W-1:0] depth_r;
  logic [HIST_CNT_W-1:0] depth_m1;

  assign depth_m1   = depth_r - HIST_CNT_W'(1);
  assign top_data   = stack_r[depth_m1[HIST_IDX_W-1:0]];
  assign stat.empty = (depth_r == '0);
  assign stat.full  = (depth_r == HIST_CNT_W'(HISTORY_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (ctl.push && !stat.full) begin
      depth_r <= depth_r + HIST_CNT_W'(1);
    end else if (ctl.pop && !stat.empty) begin
      depth_r <= depth_m1;
    end
  end

  // entries carry no reset; only written slots are ever popped
  always_ff @(posedge clk) begin
    if (ctl.push && !stat.full) begin
      stack_r[depth_r[HIST_IDX_W-1:0]] <= push_data;
    end
  end

endmodule

@@ rtl/dls_engine.sv @@
// dls_engine: link state machine, heartbeat watchdog, page and selection state.
// Computes one result per event combinationally. Depends on dls_pkg, dls_history.
module dls_engine
  import dls_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  link_mode_t         mode_r, mode_nxt;
  logic [HB_W-1:0]    hb_r, hb_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [COMP_W-1:0]  chosen_r, chosen_nxt;
  logic               valid_r, valid_nxt;
  logic [DECAY_W-1:0] decay_r, decay_nxt;

  hist_ctl_t          hctl;
  hist_stat_t         hstat;
  logic [PAGE_W-1:0]  hist_top;

  logic               go_req;
  logic               go_push;
  logic [PAGE_W-1:0]  go_target;
  logic               deselect;
  logic               linked;
  logic               oper_drop;
  logic [HB_W-1:0]    hb_reload;
  logic [HB_W-1:0]    hb_neg_span;

  assign linked      = (mode_r != MODE_DISC);
  assign hb_reload   = {1'b0, cfg.watchdog_reload};
  assign hb_neg_span = HB_W'(0) - {1'b0, cfg.retry_span};
  assign oper_drop   = (hb_r == HB_W'(1));

  dls_history u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hctl),
    .push_data (page_r),
    .top_data  (hist_top),
    .stat      (hstat)
  );

  always_comb begin
    mode_nxt   = mode_r;
    hb_nxt     = hb_r;
    page_nxt   = page_r;
    chosen_nxt = chosen_r;
    valid_nxt  = valid_r;
    decay_nxt  = decay_r;
    res        = '0;
    go_req     = 1'b0;
    go_push    = 1'b0;
    go_target  = page_r;
    deselect   = 1'b0;
    hctl       = '0;

    case (item.command)
      CMD_TICK: begin
        case (mode_r)
          MODE_OPER: begin
            res.ping_sent = 1'b1;
            if (oper_drop) mode_nxt = MODE_DISC;
            if (decay_r != '0) begin
              // highlight expires; unflagged if the link just dropped
              if (decay_r == DECAY_W'(1) && valid_r) begin
                deselect  = !oper_drop;
                valid_nxt = 1'b0;
              end
              decay_nxt = decay_r - DECAY_W'(1);
            end
            hb_nxt = hb_r - HB_W'(1);
          end
          MODE_CONN, MODE_WRONG: begin
            res.version_alert = (mode_r == MODE_WRONG);
            go_req            = 1'b1;
            go_target         = cfg.init_page;
            res.init_entered  = 1'b1;
            mode_nxt          = MODE_OPER;
            hb_nxt            = hb_reload - HB_W'(1);
          end
          MODE_DISC: begin
            if (hb_r == '0) begin
              res.reset_sent = 1'b1;
              decay_nxt      = '0;
              valid_nxt      = 1'b0;
              hb_nxt         = hb_r - HB_W'(1);
            end else if (hb_r == hb_neg_span) begin
              // retry: heartbeat set to 1 then decremented
              res.timeout_alert = 1'b1;
              hb_nxt            = '0;
            end else begin
              hb_nxt = hb_r - HB_W'(1);
            end
          end
          default: ;
        endcase
      end
      CMD_VERSION: begin
        if (item.version < cfg.min_version || item.version > cfg.max_version) begin
          mode_nxt = MODE_WRONG;
        end else begin
          mode_nxt = MODE_CONN;
        end
      end
      CMD_ECHO: begin
        if (item.page_id == page_r) hb_nxt = hb_reload;
      end
      CMD_SWITCH: begin
        go_req    = 1'b1;
        go_push   = item.push_history;
        go_target = item.page_id;
      end
      CMD_BACK: begin
        go_req = 1'b1;
        if (!hstat.empty) begin
          hctl.pop  = 1'b1;
          go_target = hist_top;
        end else begin
          go_target = cfg.fallback_page;
        end
      end
      CMD_SELECT: begin
        if (!valid_r || chosen_r != item.component_id) begin
          deselect   = valid_r && linked;
          chosen_nxt = item.component_id;
          valid_nxt  = 1'b1;
        end
        decay_nxt       = cfg.select_decay;
        res.select_sent = linked;
      end
      CMD_CLEAR: begin
        decay_nxt = '0;
        deselect  = valid_r && linked;
        valid_nxt = 1'b0;
      end
      default: ;
    endcase

    // shared page switch; mode_r is the mode at the time of sending
    if (go_req && go_target != REFUSED_PAGE) begin
      decay_nxt     = '0;
      deselect      = valid_r && linked;
      valid_nxt     = 1'b0;
      hctl.push     = go_push;
      page_nxt      = go_target;
      res.page_sent = linked;
    end

    res.deselect_sent = deselect;
    res.deselect_id   = deselect ? chosen_r : '0;
    res.link_state    = encode_mode(mode_nxt);
    res.active_page   = page_nxt;

    if (!step) hctl = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_DISC;
      hb_r     <= '0;
      page_r   <= '0;
      chosen_r <= '0;
      valid_r  <= 1'b0;
      decay_r  <= '0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      hb_r     <= hb_nxt;
      page_r   <= page_nxt;
      chosen_r <= chosen_nxt;
      valid_r  <= valid_nxt;
      decay_r  <= decay_nxt;
    end
  end

endmodule

@@ rtl/display_link_supervisor_top.sv @@
// display_link_supervisor_top: top level of the display link supervisor.
// Depends on dls_pkg, dls_if, dls_cfg, dls_engine (and dls_history below it).
//
// One event beat in, one result beat out, in order. The block takes a new
// event every cycle unless input ready drops: an event beat lands in the
// input register, and when the result register is free or draining the
// engine evaluates it against the live link state and writes the result
// register, which offers the result on the output side. The engine's
// combinational next-state logic (heartbeat compare and decrement, page
// history push/pop, selection update) sets that rate; the result register
// lets the input side keep flowing while a result waits, and input ready
// only drops when both registers are full and the result side stalls. No
// clearing pass after reset; history entries are tracked by a fill count.
// Configuration is written over the APB-style port at byte address
// 4*index and takes effect for the next event evaluated.
module display_link_supervisor_top
  import dls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  dls_in_if.sink            in_chan,
  dls_out_if.source         out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_valid_r;
  result_t res;
  result_t out_res_r;
  logic    out_valid_r;
  logic    advance;

  // advance the held event when the result register is free or draining
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  dls_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dls_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_r.command      <= in_chan.command;
      in_item_r.version      <= in_chan.version;
      in_item_r.page_id      <= in_chan.page_id;
      in_item_r.push_history <= in_chan.push_history;
      in_item_r.component_id <= in_chan.component_id;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.link_state    = out_res_r.link_state;
  assign out_chan.ping_sent     = out_res_r.ping_sent;
  assign out_chan.reset_sent    = out_res_r.reset_sent;
  assign out_chan.timeout_alert = out_res_r.timeout_alert;
  assign out_chan.version_alert = out_res_r.version_alert;
  assign out_chan.init_entered  = out_res_r.init_entered;
  assign out_chan.page_sent     = out_res_r.page_sent;
  assign out_chan.active_page   = out_res_r.active_page;
  assign out_chan.deselect_sent = out_res_r.deselect_sent;
  assign out_chan.deselect_id   = out_res_r.deselect_id;
  assign out_chan.select_sent   = out_res_r.select_sent;

endmodule

@@ rtl/dls_checker.sv @@
// dls_checker: port-level assertions for the display link supervisor, bound
// to the top level. Depends on dls_pkg.
module dls_checker
  import dls_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [LS_W-1:0]   link_state,
  input logic              ping_sent,
  input logic              reset_sent,
  input logic              init_entered,
  input logic              page_sent,
  input logic [PAGE_W-1:0] active_page,
  input logic              deselect_sent,
  input logic [COMP_W-1:0] deselect_id,
  input logic              select_sent
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(link_state) && $stable(active_page)
      && $stable(deselect_id) && $stable(ping_sent))
    else $error("result beat changed while stalled");

  // no page, select or init command goes out while disconnected; a ping may
  // go out on the tick that drops the link
  a_suppress: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && link_state == LS_DISC |-> !page_sent && !select_sent && !deselect_sent
      && !init_entered)
    else $error("link command flagged while disconnected");

  // init always lands in the operational state
  a_init_oper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && init_entered |-> link_state == LS_OPER && !reset_sent)
    else $error("init without operational state");

  // deselect id is clean when no deselect issued
  a_desel_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !deselect_sent |-> deselect_id == '0)
    else $error("stray deselect id");

endmodule

bind display_link_supervisor_top dls_checker u_dls_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .link_state    (out_chan.link_state),
  .ping_sent     (out_chan.ping_sent),
  .reset_sent    (out_chan.reset_sent),
  .init_entered  (out_chan.init_entered),
  .page_sent     (out_chan.page_sent),
  .active_page   (out_chan.active_page),
  .deselect_sent (out_chan.deselect_sent),
  .deselect_id   (out_chan.deselect_id),
  .select_sent   (out_chan.select_sent)
);
